### sv/rthsv_pkg.sv
// ----------------------------------------------------------------------------
// rthsv_pkg: shared types and constants
// Register indexes, divider sizing and the stage record passed along the
// divider cell chain.
// ----------------------------------------------------------------------------
package rthsv_pkg;

  localparam int NUM_REGS  = 8;
  localparam int IDX_W     = 3;

  localparam logic [IDX_W-1:0] REG_HUE_LOW_A  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HUE_HIGH_A = 3'd1;
  localparam logic [IDX_W-1:0] REG_HUE_LOW_B  = 3'd2;
  localparam logic [IDX_W-1:0] REG_HUE_HIGH_B = 3'd3;
  localparam logic [IDX_W-1:0] REG_SAT_LOW    = 3'd4;
  localparam logic [IDX_W-1:0] REG_SAT_HIGH   = 3'd5;
  localparam logic [IDX_W-1:0] REG_VAL_LOW    = 3'd6;
  localparam logic [IDX_W-1:0] REG_VAL_HIGH   = 3'd7;

  // Quotient bits developed per divider (both quotients fit in 8 bits)
  localparam int QBITS = 8;
  // Dividends: delta*255 < 2^16, |diff|*60 < 2^14
  localparam int NUM_W = 16;

  // Hue sector of the maximum channel
  localparam logic [1:0] SECT_RED   = 2'd0;
  localparam logic [1:0] SECT_GREEN = 2'd1;
  localparam logic [1:0] SECT_BLUE  = 2'd2;

  // One pixel in flight through the divider chain
  typedef struct packed {
    logic             valid;
    logic [7:0]       vmax;
    logic [7:0]       sat_den;   // max
    logic [NUM_W-1:0] sat_rem;   // partial remainder
    logic [QBITS-1:0] sat_q;
    logic [7:0]       hue_den;   // delta
    logic [NUM_W-1:0] hue_rem;
    logic [QBITS-1:0] hue_q;
    logic             hue_neg;
    logic             grey;
    logic [1:0]       sect;
  } stage_t;

endpackage

### sv/rthsv_div_cell.sv
// ----------------------------------------------------------------------------
// rthsv_div_cell: one restoring-division step
// Develops one quotient bit of both the saturation and hue divisions and
// hands the record to the next cell.
// ----------------------------------------------------------------------------
module rthsv_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          bit_pos,
  input  rthsv_pkg::stage_t   din,
  output rthsv_pkg::stage_t   dout
);
  import rthsv_pkg::*;

  logic [NUM_W+QBITS-1:0] sat_sub;
  logic [NUM_W+QBITS-1:0] hue_sub;
  logic                   sat_ge;
  logic                   hue_ge;
  stage_t                 step;

  // Compare partial remainder against shifted divisor
  always_comb begin
    sat_sub = {{(NUM_W+QBITS-8){1'b0}}, din.sat_den} << bit_pos;
    hue_sub = {{(NUM_W+QBITS-8){1'b0}}, din.hue_den} << bit_pos;
    sat_ge  = {{QBITS{1'b0}}, din.sat_rem} >= sat_sub;
    hue_ge  = {{QBITS{1'b0}}, din.hue_rem} >= hue_sub;
    step    = din;
    if (sat_ge) begin
      step.sat_rem = din.sat_rem - sat_sub[NUM_W-1:0];
      step.sat_q[bit_pos] = 1'b1;
    end
    if (hue_ge) begin
      step.hue_rem = din.hue_rem - hue_sub[NUM_W-1:0];
      step.hue_q[bit_pos] = 1'b1;
    end
  end

  // Advance to the neighbour every cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.vmax    <= step.vmax;
    dout.sat_den <= step.sat_den;
    dout.sat_rem <= step.sat_rem;
    dout.sat_q   <= step.sat_q;
    dout.hue_den <= step.hue_den;
    dout.hue_rem <= step.hue_rem;
    dout.hue_q   <= step.hue_q;
    dout.hue_neg <= step.hue_neg;
    dout.grey    <= step.grey;
    dout.sect    <= step.sect;
  end

endmodule

### sv/rgb_to_hsv_range_mask.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_range_mask: RGB pixel to HSV with two-window range mask
// Converts 8-bit RGB to hue/2, saturation and value and flags pixels that
// fall inside either of two hue windows with shared S and V bounds.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with red/green/blue for one cycle per pixel; busy is always
//   low, so a pixel is taken on every cycle that start is high.
//   Results appear on hue_half/saturation/brightness/in_range with done high
//   for exactly one cycle. The max/min and dividend register loads on the
//   edge that took the pixel, then the pixel passes through the chain of
//   eight divider cells (one quotient bit each), the hue offset and halving
//   register, and the window test with its output register.
//   Throughput is one pixel per clock; the cell chain holds up to eight
//   pixels at once.
//   Registers are written through cfg_we/cfg_index/cfg_data at any idle
//   cycle; every 3-bit index names a register, only 8 data bits are used.
//   Synchronous reset clears all transactions in flight and reloads the
//   default windows (hue 0..6 and 174..180, S and V 50..255).
//   The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module rgb_to_hsv_range_mask (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       done,
  output logic [7:0] hue_half,
  output logic [7:0] saturation,
  output logic [7:0] brightness,
  output logic       in_range
);
  import rthsv_pkg::*;

  logic [7:0] regs [NUM_REGS];

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_HUE_LOW_A]  <= 8'd0;
      regs[REG_HUE_HIGH_A] <= 8'd6;
      regs[REG_HUE_LOW_B]  <= 8'd174;
      regs[REG_HUE_HIGH_B] <= 8'd180;
      regs[REG_SAT_LOW]    <= 8'd50;
      regs[REG_SAT_HIGH]   <= 8'd255;
      regs[REG_VAL_LOW]    <= 8'd50;
      regs[REG_VAL_HIGH]   <= 8'd255;
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  assign busy = 1'b0;

  // Front stage: max, min, sector and dividends
  logic [7:0] mx, mn, dl;
  logic [1:0] sect;
  logic [8:0] diff_abs;
  logic       diff_neg;
  stage_t     front;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    dl = mx - mn;
    diff_neg = 1'b0;
    diff_abs = '0;
    if (red == mx) begin
      sect = SECT_RED;
      diff_neg = green < blue;
      diff_abs = diff_neg ? {1'b0, blue - green} : {1'b0, green - blue};
    end else if (green == mx) begin
      sect = SECT_GREEN;
      diff_neg = blue < red;
      diff_abs = diff_neg ? {1'b0, red - blue} : {1'b0, blue - red};
    end else begin
      sect = SECT_BLUE;
      diff_neg = red < green;
      diff_abs = diff_neg ? {1'b0, green - red} : {1'b0, red - green};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid <= 1'b0;
    end else begin
      front.valid <= start;
    end
    front.vmax    <= mx;
    front.sat_den <= mx;
    front.sat_rem <= ({8'd0, dl} << 8) - {8'd0, dl};
    front.sat_q   <= '0;
    front.hue_den <= dl;
    front.hue_rem <= ({7'd0, diff_abs} << 6) - ({7'd0, diff_abs} << 2);
    front.hue_q   <= '0;
    front.hue_neg <= diff_neg;
    front.grey    <= (dl == 8'd0);
    front.sect    <= sect;
  end

  // Chain of divider cells, MSB first
  stage_t chain [QBITS+1];
  assign chain[0] = front;

  for (genvar k = 0; k < QBITS; k++) begin : g_cell
    rthsv_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .bit_pos (3'(QBITS-1-k)),
      .din     (chain[k]),
      .dout    (chain[k+1])
    );
  end

  // Hue offset, wrap and halve
  stage_t     tail;
  logic [9:0] hue_deg;
  logic       fin_valid;
  logic [7:0] fin_hh, fin_sat, fin_v;

  assign tail = chain[QBITS];

  always_comb begin
    hue_deg = '0;
    if (!tail.grey) begin
      unique case (tail.sect)
        SECT_RED:   hue_deg = tail.hue_neg ? 10'd360 - {2'd0, tail.hue_q}
                                           : {2'd0, tail.hue_q};
        SECT_GREEN: hue_deg = tail.hue_neg ? 10'd120 - {2'd0, tail.hue_q}
                                           : 10'd120 + {2'd0, tail.hue_q};
        SECT_BLUE:  hue_deg = tail.hue_neg ? 10'd240 - {2'd0, tail.hue_q}
                                           : 10'd240 + {2'd0, tail.hue_q};
        default:    hue_deg = '0;
      endcase
      if (tail.sect == SECT_RED && tail.hue_neg && tail.hue_q == 8'd0) hue_deg = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else begin
      fin_valid <= tail.valid;
    end
    fin_hh  <= hue_deg[8:1];
    fin_sat <= (tail.sat_den == 8'd0) ? 8'd0 : tail.sat_q;
    fin_v   <= tail.vmax;
  end

  // Window test and output register
  logic sv_ok, hit;
  always_comb begin
    sv_ok = fin_sat >= regs[REG_SAT_LOW] && fin_sat <= regs[REG_SAT_HIGH] &&
            fin_v >= regs[REG_VAL_LOW] && fin_v <= regs[REG_VAL_HIGH];
    hit = sv_ok &&
          ((fin_hh >= regs[REG_HUE_LOW_A] && fin_hh <= regs[REG_HUE_HIGH_A]) ||
           (fin_hh >= regs[REG_HUE_LOW_B] && fin_hh <= regs[REG_HUE_HIGH_B]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin_valid;
    end
    hue_half   <= fin_hh;
    saturation <= fin_sat;
    brightness <= fin_v;
    in_range   <= hit;
  end

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    done |-> hue_half <= 8'd179) else $error("hue_half out of range");
  a_sat_grey: assert property (@(posedge clk) disable iff (rst)
    done && brightness == 8'd0 |-> saturation == 8'd0) else $error("black with saturation");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    fin_valid |=> done) else $error("result lost at output");
  a_mask_sv: assert property (@(posedge clk) disable iff (rst)
    done && in_range |-> $past(sv_ok)) else $error("mask without S/V match");

endmodule
